[src/ppt_pkg.sv]
// Package for the point-to-polygon tangent search core.
// Holds default parameter values, fixed field widths and the status codes.
// No dependencies.
package ppt_pkg;

  localparam int unsigned MAX_VERTICES_DEF = 256;
  localparam int unsigned COORD_WIDTH_DEF  = 16;

  localparam int unsigned INDEX_WIDTH  = 8;
  localparam int unsigned STATUS_WIDTH = 2;
  localparam int unsigned RESULT_BITS  = 2 * INDEX_WIDTH + STATUS_WIDTH;
  localparam int unsigned OUT_TDATA_W  = ((RESULT_BITS + 7) / 8) * 8;

  typedef enum logic [STATUS_WIDTH-1:0] {
    STATUS_OK   = 2'd0,
    STATUS_FEW  = 2'd1,
    STATUS_MANY = 2'd2
  } status_e;

endpackage

[src/point_polygon_tangents_core.sv]
// Top level of the point-to-polygon tangent search core.
// Depends on ppt_pkg for default parameters, widths and status codes.
//
// Vertices arrive one beat per clock cycle, and the core takes a new beat in every cycle
// while its result register is free or being drained. Each beat passes an input register
// and is then judged combinationally, and judging the beat marked last loads the result
// register. The judging holds the loop that sets the rate: seven independent exact cross
// products, one multiplier deep, whose signs choose the next tangent vertices
// combinationally. The exterior point is taken from the first beat of each polygon only.
module point_polygon_tangents_core #(
  parameter int unsigned MAX_VERTICES = ppt_pkg::MAX_VERTICES_DEF,
  parameter int unsigned COORD_WIDTH  = ppt_pkg::COORD_WIDTH_DEF
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     s_axis_tvalid_i,
  output logic                                     s_axis_tready_o,
  // Fields from bit 0: vertex_x, vertex_y, point_x, point_y, zero fill.
  input  logic [((4*COORD_WIDTH+7)/8)*8-1:0]       s_axis_tdata_i,
  input  logic                                     s_axis_tlast_i,
  output logic                                     m_axis_tvalid_o,
  input  logic                                     m_axis_tready_i,
  // Fields from bit 0: right_index, left_index, status, zero fill.
  output logic [ppt_pkg::OUT_TDATA_W-1:0]          m_axis_tdata_o
);
  import ppt_pkg::*;

  localparam int unsigned CW   = COORD_WIDTH;
  localparam int unsigned DW   = CW + 1;
  localparam int unsigned PW   = 2 * DW;
  localparam int unsigned XW   = PW + 1;
  localparam int unsigned CNTW = $clog2(MAX_VERTICES + 1);
  localparam int unsigned PADW = OUT_TDATA_W - RESULT_BITS;

  typedef logic signed [CW-1:0] coord_t;
  typedef logic [INDEX_WIDTH-1:0] index_t;
  typedef logic [CNTW-1:0] count_t;

  // Exact isLeft(A, B, P) = (Bx-Ax)*(Py-Ay) - (Px-Ax)*(By-Ay).
  function automatic logic signed [XW-1:0] is_left(input coord_t ax, input coord_t ay,
                                                   input coord_t bx, input coord_t by,
                                                   input coord_t px, input coord_t py);
    logic signed [DW-1:0] ux, uy, wx, wy;
    logic signed [PW-1:0] p0, p1;
    ux = DW'(bx) - DW'(ax);
    uy = DW'(by) - DW'(ay);
    wx = DW'(px) - DW'(ax);
    wy = DW'(py) - DW'(ay);
    p0 = PW'(ux) * PW'(wy);
    p1 = PW'(wx) * PW'(uy);
    return XW'(p0) - XW'(p1);
  endfunction

  function automatic index_t sat_index(input count_t v);
    logic [31:0] w;
    w = 32'(v);
    return (w > 32'd255) ? index_t'(8'hFF) : w[INDEX_WIDTH-1:0];
  endfunction

  // Input register.
  logic   in_valid_q, in_last_q;
  coord_t in_vx_q, in_vy_q, in_px_q, in_py_q;

  // Polygon state.
  coord_t pt_x_q, pt_y_q, first_x_q, first_y_q, prev_x_q, prev_y_q;
  coord_t right_x_q, right_y_q, left_x_q, left_y_q;
  logic   prev_turn_q, overflowed_q;
  count_t count_q;
  index_t right_best_q, left_best_q;

  // Result register.
  logic    out_valid_q;
  index_t  out_right_q, out_left_q;
  status_e out_status_q;

  logic advance, consume;
  assign advance = !in_last_q || !out_valid_q || m_axis_tready_i;
  assign consume = in_valid_q && advance;
  assign s_axis_tready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_vx_q   <= s_axis_tdata_i[CW-1:0];
      in_vy_q   <= s_axis_tdata_i[2*CW-1:CW];
      in_px_q   <= s_axis_tdata_i[3*CW-1:2*CW];
      in_py_q   <= s_axis_tdata_i[4*CW-1:3*CW];
      in_last_q <= s_axis_tlast_i;
    end
  end

  // Judging of one beat.
  logic is_first, is_second, is_full;
  logic np1, r1_neg, l1_pos, t2, r2o_neg, l2o_pos;
  logic signed [XW-1:0] c2p;
  logic upd_r1, upd_l1, upd_r2, upd_l2, run_j1, run_j2;
  count_t idx_prev;
  index_t right_fin, left_fin;

  assign is_full   = (count_q >= count_t'(MAX_VERTICES));
  assign is_first  = (count_q == '0);
  assign is_second = (count_q == count_t'(1));
  assign idx_prev  = count_q - count_t'(1);

  assign np1     = is_left(prev_x_q, prev_y_q, in_vx_q, in_vy_q, pt_x_q, pt_y_q) > 0;
  assign r1_neg  = is_left(pt_x_q, pt_y_q, prev_x_q, prev_y_q, right_x_q, right_y_q) < 0;
  assign l1_pos  = is_left(pt_x_q, pt_y_q, prev_x_q, prev_y_q, left_x_q, left_y_q) > 0;
  assign t2      = is_left(in_vx_q, in_vy_q, first_x_q, first_y_q, pt_x_q, pt_y_q) > 0;
  assign r2o_neg = is_left(pt_x_q, pt_y_q, in_vx_q, in_vy_q, right_x_q, right_y_q) < 0;
  assign l2o_pos = is_left(pt_x_q, pt_y_q, in_vx_q, in_vy_q, left_x_q, left_y_q) > 0;
  assign c2p     = is_left(pt_x_q, pt_y_q, in_vx_q, in_vy_q, prev_x_q, prev_y_q);

  assign run_j1 = !is_full && !is_first && !is_second;
  assign run_j2 = !is_full && !is_first && in_last_q;
  assign upd_r1 = run_j1 && !prev_turn_q && np1 && !r1_neg;
  assign upd_l1 = run_j1 && prev_turn_q && !np1 && !l1_pos;
  assign upd_r2 = run_j2 && !np1 && t2 && !(upd_r1 ? (c2p < 0) : r2o_neg);
  assign upd_l2 = run_j2 && np1 && !t2 && !(upd_l1 ? (c2p > 0) : l2o_pos);

  assign right_fin = upd_r2 ? sat_index(count_q) :
                     upd_r1 ? sat_index(idx_prev) : right_best_q;
  assign left_fin  = upd_l2 ? sat_index(count_q) :
                     upd_l1 ? sat_index(idx_prev) : left_best_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q      <= '0;
      overflowed_q <= 1'b0;
      prev_turn_q  <= 1'b0;
      right_best_q <= '0;
      left_best_q  <= '0;
    end else if (consume) begin
      if (in_last_q) begin
        count_q      <= '0;
        overflowed_q <= 1'b0;
      end else if (is_full) begin
        overflowed_q <= 1'b1;
      end else begin
        count_q <= count_q + count_t'(1);
      end
      if (!is_full) begin
        prev_turn_q  <= is_first ? 1'b0 : np1;
        right_best_q <= is_first ? '0 : right_fin;
        left_best_q  <= is_first ? '0 : left_fin;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (consume && !is_full) begin
      prev_x_q <= in_vx_q;
      prev_y_q <= in_vy_q;
      if (is_first) begin
        pt_x_q    <= in_px_q;
        pt_y_q    <= in_py_q;
        first_x_q <= in_vx_q;
        first_y_q <= in_vy_q;
        right_x_q <= in_vx_q;
        right_y_q <= in_vy_q;
        left_x_q  <= in_vx_q;
        left_y_q  <= in_vy_q;
      end else begin
        if (upd_r2) begin
          right_x_q <= in_vx_q;
          right_y_q <= in_vy_q;
        end else if (upd_r1) begin
          right_x_q <= prev_x_q;
          right_y_q <= prev_y_q;
        end
        if (upd_l2) begin
          left_x_q <= in_vx_q;
          left_y_q <= in_vy_q;
        end else if (upd_l1) begin
          left_x_q <= prev_x_q;
          left_y_q <= prev_y_q;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (consume && in_last_q) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (consume && in_last_q) begin
      if (overflowed_q || is_full) begin
        out_status_q <= STATUS_MANY;
        out_right_q  <= '1;
        out_left_q   <= '1;
      end else if (is_first) begin
        out_status_q <= STATUS_FEW;
        out_right_q  <= '0;
        out_left_q   <= '0;
      end else begin
        out_status_q <= STATUS_OK;
        out_right_q  <= right_fin;
        out_left_q   <= left_fin;
      end
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {PADW'(0), out_status_q, out_left_q, out_right_q};

  a_result_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(in_valid_q && in_last_q))
    else $error("Result appeared without a last beat being judged.");

  a_few_zero_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_status_q == STATUS_FEW) |-> (out_right_q == '0 && out_left_q == '0))
    else $error("Single-vertex result carries non-zero indices.");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= count_t'(MAX_VERTICES))
    else $error("Vertex count ran past its limit.");

  a_overflow_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    overflowed_q |-> (count_q == count_t'(MAX_VERTICES)))
    else $error("Overflow flag set while the vertex count is below its limit.");

endmodule
